### hdl/ittr_pkg.sv
package ittr_pkg;

	// fixed field widths
	localparam int VALUE_W = 32;
	localparam int CHAR_W  = 8;
	localparam int APB_DW  = 32;
	localparam int APB_AW  = 3;

	// register word index (paddr[2])
	localparam logic REG_NUMBER_BASE = 1'b0;

	// character codes
	localparam logic [CHAR_W-1:0] CHAR_ZERO        = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_MINUS       = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_X           = 8'h78;
	localparam logic [CHAR_W-1:0] CHAR_B           = 8'h62;
	localparam logic [CHAR_W-1:0] HEX_ALPHA_OFFSET = 8'd55;

	typedef enum logic [1:0] {
		RADIX_BIN = 2'd0,
		RADIX_OCT = 2'd1,
		RADIX_DEC = 2'd2,
		RADIX_HEX = 2'd3
	} radix_t;

	typedef enum logic [1:0] {
		CH_MINUS  = 2'd0,
		CH_ZERO   = 2'd1,
		CH_PREFIX = 2'd2,
		CH_DIGIT  = 2'd3
	} char_sel_t;

	// controller -> datapath
	typedef struct packed {
		logic      load;
		logic      conv_step;
		logic      skip;
		logic      emit;
		char_sel_t sel;
		logic      last;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		radix_t radix;
		logic   neg;
		logic   cnt_one;
		logic   digit_zero;
		logic   out_free;
	} ctl_sts_t;

endpackage

### hdl/ittr_in_if.sv
interface ittr_in_if;
	import ittr_pkg::*;

	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;
	logic               is_signed;
	logic               force_hex;

	modport source (output valid, value, is_signed, force_hex, input ready);
	modport sink (input valid, value, is_signed, force_hex, output ready);

endinterface

### hdl/ittr_out_if.sv
interface ittr_out_if;
	import ittr_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              last;

	modport source (output valid, char_code, last, input ready);
	modport sink (input valid, char_code, last, output ready);

endinterface

### hdl/ittr_ctrl.sv
module ittr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ittr_pkg::ctl_sts_t sts,
	output ittr_pkg::ctl_cmd_t cmd
);
	import ittr_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_PRE0,
		ST_PREX,
		ST_DIGIT,
		ST_TAIL
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   lead_zero;

	// a zero digit ahead of the first nonzero one is dropped, unless it is the final position
	assign lead_zero = sts.digit_zero && !sts.cnt_one;
	assign in_ready  = (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.sel = CH_DIGIT;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CONV;
				end
			end
			ST_CONV: begin
				if (sts.radix != RADIX_DEC) begin
					state_d = ST_SIGN;
				end else begin
					cmd.conv_step = 1'b1;
					if (sts.cnt_one) state_d = ST_SIGN;
				end
			end
			ST_SIGN: begin
				cmd.skip = lead_zero;
				if (!sts.neg) begin
					state_d = ST_PRE0;
				end else if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = CH_MINUS;
					state_d  = ST_PRE0;
				end
			end
			ST_PRE0: begin
				cmd.skip = lead_zero;
				if (sts.radix == RADIX_DEC) begin
					state_d = ST_DIGIT;
				end else if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = CH_ZERO;
					if (sts.radix inside {RADIX_BIN, RADIX_HEX}) state_d = ST_PREX;
					else state_d = ST_DIGIT;
				end
			end
			ST_PREX: begin
				cmd.skip = lead_zero;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = CH_PREFIX;
					state_d  = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				if (lead_zero) begin
					cmd.skip = 1'b1;
				end else if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = CH_DIGIT;
					cmd.last = sts.cnt_one;
					state_d  = sts.cnt_one ? ST_IDLE : ST_TAIL;
				end
			end
			// after the first nonzero digit every position is printed
			ST_TAIL: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = CH_DIGIT;
					cmd.last = sts.cnt_one;
					if (sts.cnt_one) state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_accept_to_conv: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_CONV))
		else $error("accepted item did not start conversion");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.last) |=> (state_q == ST_IDLE))
		else $error("final character did not end the item");

	a_tail_no_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAIL) |-> !cmd.skip)
		else $error("digit dropped after the first nonzero digit");

endmodule

### hdl/ittr_dp.sv
module ittr_dp #(
	parameter int VALUE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ittr_pkg::ctl_cmd_t            cmd,
	output ittr_pkg::ctl_sts_t            sts,
	input  ittr_pkg::radix_t              base,
	input  logic [ittr_pkg::VALUE_W-1:0]  value,
	input  logic                          is_signed,
	input  logic                          force_hex,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [ittr_pkg::CHAR_W-1:0]   char_code,
	output logic                          last
);
	import ittr_pkg::*;

	// decimal digits of 2^VALUE_BITS, then a digit register whose width
	// divides by 1, 3 and 4 so every radix has whole digit positions
	localparam int NDEC  = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int DW    = 12 * ((NDEC * 4 + 11) / 12);
	localparam int CNT_W = $clog2(DW + 1);

	logic [VALUE_BITS-1:0] v_in;
	logic [VALUE_BITS-1:0] mag_in;
	logic                  neg_in;
	radix_t                radix_in;
	logic [DW-1:0]         dig_in;
	logic [CNT_W-1:0]      cnt_in;

	logic [VALUE_BITS-1:0] mag_q;
	logic [DW-1:0]         dig_q;
	logic [DW-1:0]         dig_adj;
	logic [DW-1:0]         dig_shift;
	logic [CNT_W-1:0]      cnt_q;
	radix_t                radix_q;
	logic                  neg_q;
	logic [3:0]            digit;
	logic [CHAR_W-1:0]     digit_char;
	logic [CHAR_W-1:0]     char_d;
	logic                  advance;
	logic                  out_valid_q;
	logic [CHAR_W-1:0]     char_q;
	logic                  last_q;

	// fit the input word to the value width
	generate
		if (VALUE_BITS <= VALUE_W) begin : g_trunc
			assign v_in = value[VALUE_BITS-1:0];
		end else begin : g_ext
			assign v_in = {{(VALUE_BITS - VALUE_W){1'b0}}, value};
		end
	endgenerate

	// decode the item: radix, sign, magnitude
	assign radix_in = force_hex ? RADIX_HEX : base;
	assign neg_in   = !force_hex && is_signed && v_in[VALUE_BITS-1];
	assign mag_in   = neg_in ? ((~v_in) + {{(VALUE_BITS - 1){1'b0}}, 1'b1}) : v_in;
	assign dig_in   = {{(DW - VALUE_BITS){1'b0}}, mag_in};

	always_comb begin
		case (radix_in)
			RADIX_BIN: cnt_in = CNT_W'(DW);
			RADIX_OCT: cnt_in = CNT_W'(DW / 3);
			RADIX_DEC: cnt_in = CNT_W'(VALUE_BITS);
			default:   cnt_in = CNT_W'(DW / 4);
		endcase
	end

	// double-dabble correction on every BCD digit
	always_comb begin
		for (int i = 0; i < DW / 4; i++) begin
			if (dig_q[4*i +: 4] >= 4'd5) dig_adj[4*i +: 4] = dig_q[4*i +: 4] + 4'd3;
			else dig_adj[4*i +: 4] = dig_q[4*i +: 4];
		end
	end

	// top digit and the shift that drops it
	always_comb begin
		case (radix_q)
			RADIX_BIN: begin
				digit     = {3'b000, dig_q[DW-1]};
				dig_shift = {dig_q[DW-2:0], 1'b0};
			end
			RADIX_OCT: begin
				digit     = {1'b0, dig_q[DW-1 -: 3]};
				dig_shift = {dig_q[DW-4:0], 3'b000};
			end
			default: begin
				digit     = dig_q[DW-1 -: 4];
				dig_shift = {dig_q[DW-5:0], 4'b0000};
			end
		endcase
	end

	assign digit_char = (digit < 4'd10) ? (CHAR_ZERO + {4'b0000, digit})
	                                    : (HEX_ALPHA_OFFSET + {4'b0000, digit});

	always_comb begin
		case (cmd.sel)
			CH_MINUS:  char_d = CHAR_MINUS;
			CH_ZERO:   char_d = CHAR_ZERO;
			CH_PREFIX: char_d = (radix_q == RADIX_BIN) ? CHAR_B : CHAR_X;
			default:   char_d = digit_char;
		endcase
	end

	assign advance = cmd.skip || (cmd.emit && cmd.sel == CH_DIGIT);

	// load, convert, walk digit positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= cnt_in;
		end else if (cmd.conv_step) begin
			cnt_q <= (cnt_q == CNT_W'(1)) ? CNT_W'(DW / 4) : cnt_q - CNT_W'(1);
		end else if (advance) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			radix_q <= radix_in;
			neg_q   <= neg_in;
			mag_q   <= mag_in;
			dig_q   <= (radix_in == RADIX_DEC) ? '0 : dig_in;
		end else if (cmd.conv_step) begin
			dig_q <= {dig_adj[DW-2:0], mag_q[VALUE_BITS-1]};
			mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
		end else if (advance) begin
			dig_q <= dig_shift;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			char_q <= char_d;
			last_q <= cmd.last;
		end
	end

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last      = last_q;

	assign sts.radix      = radix_q;
	assign sts.neg        = neg_q;
	assign sts.cnt_one    = (cnt_q == CNT_W'(1));
	assign sts.digit_zero = (digit == 4'd0);
	assign sts.out_free   = !out_valid_q || out_ready;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("character overwrote a pending item");

	a_cnt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> (cnt_q != '0))
		else $error("digit walk ran past the last position");

	a_conv_dec_only: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.conv_step |-> (radix_q == RADIX_DEC))
		else $error("BCD conversion outside decimal");

endmodule

### hdl/integer_to_text_radix.sv
// Order: accept, decode (with VALUE_BITS BCD steps for decimal), then the minus sign if any,
// the prefix for bin/oct/hex, and the digits, leading zeros dropped one position at a time.
// Throughput: one item at a time; decode, the BCD steps (decimal only), sign/prefix states and
// every digit position (48 bin, 16 oct, 12 dec/hex at 32 bits) all come before the next accept.
// Sign/prefix cycles also drop leading zeros; characters leave at one per cycle via one register
// while out_ready is high. Reset: arst_n clears control and sets number_base to decimal.
module integer_to_text_radix #(
	parameter int VALUE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	ittr_in_if.sink                       in_ch,
	ittr_out_if.source                    out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ittr_pkg::APB_AW-1:0]   paddr,
	input  logic [ittr_pkg::APB_DW-1:0]   pwdata,
	output logic [ittr_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);
	import ittr_pkg::*;

	radix_t   base_q;
	ctl_cmd_t cmd;
	ctl_sts_t sts;
	logic     in_ready;

	// configuration register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= RADIX_DEC;
		end else if (psel && penable && pwrite && paddr[2] == REG_NUMBER_BASE) begin
			base_q <= radix_t'(pwdata[1:0]);
		end
	end

	assign prdata = (paddr[2] == REG_NUMBER_BASE) ? {{(APB_DW - 2){1'b0}}, base_q} : '0;

	assign in_ch.ready = in_ready;

	ittr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ittr_dp #(
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.base      (base_q),
		.value     (in_ch.value),
		.is_signed (in_ch.is_signed),
		.force_hex (in_ch.force_hex),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.char_code (out_ch.char_code),
		.last      (out_ch.last)
	);

endmodule

### tb/testbench.sv
module testbench;
	import ittr_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = VALUE_W + 8;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_ITEMS    = 18;

	localparam logic [APB_AW-1:0] ADDR_NUMBER_BASE = {REG_NUMBER_BASE, 2'b00};
	localparam logic [APB_AW-1:0] ADDR_UNMAPPED    = {~REG_NUMBER_BASE, 2'b00};

	typedef struct packed {
		logic [CHAR_W-1:0] ch_code;
		logic              last;
	} text_char_t;

	// Predicts the text of each accepted number and checks the characters in order
	class text_scoreboard;
		text_char_t text_due[$];
		radix_t     base;
		int         errors;
		int         numbers;
		int         chars;

		function new();
			base    = RADIX_DEC;
			errors  = 0;
			numbers = 0;
			chars   = 0;
		endfunction

		function void set_base(logic [1:0] code);
			base = radix_t'(code);
		endfunction

		function int pending();
			return text_due.size();
		endfunction

		task report(string what);
			$display("MISMATCH at %0t: %s", $time, what);
			errors++;
		endtask

		// Build sign, prefix and digits of one number
		function void note_number(logic [VALUE_W-1:0] value, logic is_signed, logic force_hex);
			logic [VALUE_W-1:0] mag;
			radix_t             radix;
			int unsigned        div;
			int unsigned        d;
			logic [CHAR_W-1:0]  text[$];
			logic [CHAR_W-1:0]  digits[$];
			text_char_t         tc;
			mag   = value;
			radix = force_hex ? RADIX_HEX : base;
			if (!force_hex && is_signed && value[VALUE_W-1]) begin
				text.push_back(CHAR_MINUS);
				mag = -value;
			end
			case (radix)
				RADIX_BIN: begin
					text.push_back(CHAR_ZERO);
					text.push_back(CHAR_B);
					div = 2;
				end
				RADIX_OCT: begin
					text.push_back(CHAR_ZERO);
					div = 8;
				end
				RADIX_HEX: begin
					text.push_back(CHAR_ZERO);
					text.push_back(CHAR_X);
					div = 16;
				end
				default: div = 10;
			endcase
			// Peel digits least significant first, emit most significant first
			do begin
				d = mag % div;
				digits.push_front(d < 10 ? CHAR_ZERO + 8'(d) : HEX_ALPHA_OFFSET + 8'(d));
				mag = mag / div;
			end while (mag != 0);
			foreach (digits[i])
				text.push_back(digits[i]);
			foreach (text[i]) begin
				tc.ch_code = text[i];
				tc.last    = (i == text.size() - 1);
				text_due.push_back(tc);
			end
			numbers++;
		endfunction

		task check_char(logic [CHAR_W-1:0] ch_code, logic last);
			text_char_t want;
			chars++;
			if (text_due.size() == 0) begin
				report($sformatf("character 0x%02h with no text pending", ch_code));
			end else begin
				want = text_due.pop_front();
				if (ch_code !== want.ch_code)
					report($sformatf("char_code 0x%02h, want 0x%02h", ch_code, want.ch_code));
				if (last !== want.last)
					report($sformatf("last %b on 0x%02h, want %b", last, ch_code, want.last));
			end
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [APB_DW-1:0]   pwdata;
	logic [APB_DW-1:0]   prdata;
	logic                pready;
	logic                tx_steady;
	logic                rx_steady;
	int                  idle_cycles;

	text_scoreboard sb = new();

	ittr_in_if  in_ch();
	ittr_out_if out_ch();

	integer_to_text_radix #(
		.VALUE_BITS(VALUE_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Note accepted numbers and check accepted characters
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready)
			sb.note_number(in_ch.value, in_ch.is_signed, in_ch.force_hex);
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_char(out_ch.char_code, out_ch.last);
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(psel && penable))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Stall the character side a random number of cycles per character, unless rx_steady
	initial begin
		int stall;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = rx_steady ? 0 : $urandom_range(0, 17);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	task apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr[2] == REG_NUMBER_BASE)
			sb.set_base(data[1:0]);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Read number_base back and compare with the model copy
	task apb_check_base();
		logic [APB_DW-1:0] got;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_NUMBER_BASE;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		if (got !== {{(APB_DW-2){1'b0}}, sb.base})
			sb.report($sformatf("number_base read 0x%08h, want %0d", got, sb.base));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one number after a random gap and hold it until accepted
	task send_number(logic [VALUE_W-1:0] value, logic is_signed, logic force_hex);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.value     <= value;
		in_ch.is_signed <= is_signed;
		in_ch.force_hex <= force_hex;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// Drop valid and wait until every pending character has come out
	task drain_text();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task set_number_base(radix_t radix);
		drain_text();
		apb_write(ADDR_NUMBER_BASE, ($urandom & ~32'h3) | APB_DW'(radix));
		apb_check_base();
	endtask

	// Extremes in the current radix, and one forced to hex
	task send_extremes();
		send_number(32'h0000_0000, 1'b0, 1'b0);
		send_number(32'hFFFF_FFFF, 1'b0, 1'b0);
		send_number(32'h8000_0000, 1'b1, 1'b0);
		send_number(32'h7FFF_FFFF, 1'b1, 1'b0);
		send_number(32'hFFFF_FFFF, 1'b1, 1'b0);
		send_number(32'h8000_0000, 1'b1, 1'b1);
	endtask

	function logic [VALUE_W-1:0] pick_value();
		int k;
		k = $urandom_range(0, VALUE_W - 1);
		case ($urandom_range(0, 4))
			0, 1: return $urandom;
			2: return $urandom_range(0, 40);
			3: return $urandom_range(0, 1) ? (32'h1 << k) : (32'h1 << k) - 1;
			default: return -$urandom_range(1, 40);
		endcase
	endfunction

	initial begin
		radix_t phase_base;
		arst_n          <= 1'b0;
		psel            <= 1'b0;
		penable         <= 1'b0;
		pwrite          <= 1'b0;
		paddr           <= '0;
		pwdata          <= '0;
		in_ch.valid     <= 1'b0;
		in_ch.value     <= '0;
		in_ch.is_signed <= 1'b0;
		in_ch.force_hex <= 1'b0;
		tx_steady       = 1'b0;
		rx_steady       = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset radix is decimal
		apb_check_base();
		send_extremes();

		// Ignore a write to an unmapped register
		drain_text();
		apb_write(ADDR_UNMAPPED, APB_DW'(RADIX_BIN));
		apb_check_base();
		send_number(32'd12345, 1'b0, 1'b0);

		set_number_base(RADIX_BIN);
		send_extremes();
		set_number_base(RADIX_OCT);
		send_extremes();
		set_number_base(RADIX_HEX);
		send_extremes();

		// Random numbers over several radix settings
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: phase_base = RADIX_BIN;
				1: phase_base = RADIX_HEX;
				2: phase_base = RADIX_OCT;
				3: phase_base = RADIX_DEC;
				default: phase_base = radix_t'($urandom_range(0, 3));
			endcase
			set_number_base(phase_base);
			if ($urandom_range(0, 2) == 0) begin
				apb_write(ADDR_UNMAPPED, $urandom);
				apb_check_base();
			end
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// Hold off midway through phase 2 until the text so far has drained
				if (p == 2 && i == PHASE_ITEMS / 2)
					drain_text();
				send_number(pick_value(), 1'($urandom_range(0, 1)),
					$urandom_range(0, 5) == 0);
			end
		end

		drain_text();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d characters never came out", sb.pending()));

		$display("Converted %0d numbers into %0d characters in all four radixes,",
			sb.numbers, sb.chars);
		$display("with signed extremes, pointer-style hex and register write/read-back.");
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
